>>> rtl/core/psit_pkg.sv
// psit_pkg: shared types and constants for the periodic sphere inclusion table
// holds the item structs, the op codes, the register map and the datapath control struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package psit_pkg;

  // item op codes
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  // register indexes on the configuration port
  localparam logic [1:0] REG_BOX_X = 2'd0;
  localparam logic [1:0] REG_BOX_Y = 2'd1;
  localparam logic [1:0] REG_BOX_Z = 2'd2;

  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned COUNT_W  = 11;

  // squares per entry: six axis offsets and one diameter
  localparam int unsigned SQ_COUNT  = 7;
  localparam int unsigned IMG_COUNT = 8;
  localparam int unsigned STEP_W    = 3;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [30:0]        diameter;
  } in_item_t;

  typedef struct packed {
    logic               inside_res;
    logic [COUNT_W-1:0] entry_count;
    logic               status;
  } out_item_t;

  // one stored sphere
  typedef struct packed {
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic [30:0] diameter;
  } sphere_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  typedef struct packed {
    logic [30:0] x;
    logic [30:0] y;
    logic [30:0] z;
  } box_t;

  // sequencer to datapath control
  typedef struct packed {
    logic              load_mag;
    logic              mul_en;
    logic [STEP_W-1:0] mul_sel;
    logic [STEP_W-1:0] img_sel;
  } dist_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/psit_image_unit.sv
// psit_image_unit: distance datapath for one stored sphere and its eight periodic images
// one shared squaring multiplier, squares kept in registers, one image compared per step
// depends on psit_pkg
`timescale 1ns / 1ps
`default_nettype none

module psit_image_unit
  import psit_pkg::*;
(
  input  wire logic       clk_i,
  input  wire dist_ctrl_t ctrl_i,
  input  wire sphere_t    entry_i,
  input  wire point_t     point_i,
  input  wire box_t       box_i,
  output logic            hit_o
);

  // signed offset shift + center - point, exact in 34 bits
  function automatic logic [33:0] axis_diff(input logic [31:0] c, input logic [31:0] p,
                                            input logic [30:0] box, input logic add_box);
    logic [33:0] c_ext;
    logic [33:0] p_ext;
    logic [33:0] b_ext;
    c_ext = {{2{c[31]}}, c};
    p_ext = {{2{p[31]}}, p};
    b_ext = add_box ? {3'b000, box} : 34'd0;
    return c_ext - p_ext + b_ext;
  endfunction

  logic [33:0] diff_w [6];
  logic [33:0] abs_w  [6];

  logic [30:0] mag_q [6];
  logic [5:0]  ovf_q;
  logic [30:0] diam_q;
  logic [61:0] sq_q  [SQ_COUNT];

  logic [30:0] mul_a;
  logic [61:0] prod;

  logic [2:0]  xi;
  logic [2:0]  yi;
  logic [2:0]  zi;
  logic [63:0] dd;
  logic        img_ok;

  // axis offsets: index is axis * 2 + shifted
  always_comb begin
    diff_w[0] = axis_diff(entry_i.center_x, point_i.x, box_i.x, 1'b0);
    diff_w[1] = axis_diff(entry_i.center_x, point_i.x, box_i.x, 1'b1);
    diff_w[2] = axis_diff(entry_i.center_y, point_i.y, box_i.y, 1'b0);
    diff_w[3] = axis_diff(entry_i.center_y, point_i.y, box_i.y, 1'b1);
    diff_w[4] = axis_diff(entry_i.center_z, point_i.z, box_i.z, 1'b0);
    diff_w[5] = axis_diff(entry_i.center_z, point_i.z, box_i.z, 1'b1);
    for (int k = 0; k < 6; k++) begin
      abs_w[k] = diff_w[k][33] ? (~diff_w[k] + 34'd1) : diff_w[k];
    end
  end

  // magnitudes, with a flag where the offset reaches 2^31 and can never hit
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_mag) begin
      for (int k = 0; k < 6; k++) begin
        mag_q[k] <= abs_w[k][30:0];
        ovf_q[k] <= |abs_w[k][33:31];
      end
      diam_q <= entry_i.diameter;
    end
  end

  // shared squaring unit, last step squares the diameter
  assign mul_a = (ctrl_i.mul_sel < STEP_W'(SQ_COUNT - 1)) ? mag_q[ctrl_i.mul_sel] : diam_q;
  assign prod  = {31'd0, mul_a} * {31'd0, mul_a};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      sq_q[ctrl_i.mul_sel] <= prod;
    end
  end

  // image compare: 4 * dd < diameter^2
  assign xi     = {2'b00, ctrl_i.img_sel[2]};
  assign yi     = {2'b01, ctrl_i.img_sel[1]};
  assign zi     = {2'b10, ctrl_i.img_sel[0]};
  assign img_ok = ~(ovf_q[xi] | ovf_q[yi] | ovf_q[zi]);
  assign dd     = {2'b00, sq_q[xi]} + {2'b00, sq_q[yi]} + {2'b00, sq_q[zi]};
  assign hit_o  = img_ok && ({dd, 2'b00} < {4'b0000, sq_q[SQ_COUNT-1]});

endmodule

`default_nettype wire

>>> rtl/core/periodic_sphere_inclusion_table.sv
// periodic_sphere_inclusion_table: clear and append items and empty-table queries give their
// result in the cycle after the transfer; other queries scan the stored spheres (read, load,
// seven squarings on the shared multiplier, eight image compares per entry) and stop at a hit.
// one item at a time: the next item is taken once the result register is loaded and free.
// reset clears the sphere count and box lengths; the sphere memory keeps its contents.
`timescale 1ns / 1ps
`default_nettype none

module periodic_sphere_inclusion_table
  import psit_pkg::*;
#(
  parameter int unsigned MAX_SPHERES = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // item input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_item_t           in_data_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_item_t               out_data_o,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned CntW  = $clog2(MAX_SPHERES + 1);
  localparam int unsigned AddrW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MAG,
    S_MUL,
    S_CMP,
    S_RESULT
  } state_e;

  function automatic logic [COUNT_W-1:0] count_out(input logic [CntW-1:0] f);
    logic [CntW+COUNT_W-1:0] ext;
    ext = {{COUNT_W{1'b0}}, f};
    return ext[COUNT_W-1:0];
  endfunction

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic [CntW-1:0]   idx_q;
  logic [CntW-1:0]   fill_q;
  logic              inside_q;
  point_t            pt_q;
  logic              out_valid_q;
  out_item_t         out_q;

  box_t              box_q;

  sphere_t           mem [MAX_SPHERES];
  sphere_t           rdata_q;

  logic              out_free;
  logic              accepted;
  logic              out_load;
  logic              full;
  logic              last;
  logic              wr_en;
  logic              rd_en;
  logic              hit;
  logic [CntW-1:0]   fill_inc;
  logic [CntW-1:0]   idx_inc;
  dist_ctrl_t        ctrl;
  sphere_t           wdata;

  // handshake
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = ~((state_q == S_IDLE) && out_free);
  assign accepted   = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // result register loads on a direct item or at the end of a scan
  assign out_load = (accepted && ((in_data_i.op != OP_QUERY) || (fill_q == '0))) ||
                    ((state_q == S_RESULT) && out_free);

  assign full     = (fill_q == CntW'(MAX_SPHERES));
  assign fill_inc = fill_q + {{(CntW-1){1'b0}}, 1'b1};
  assign idx_inc  = idx_q + {{(CntW-1){1'b0}}, 1'b1};
  assign last     = (idx_inc == fill_q);

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_BOX_X: box_q.x <= pwdata[30:0];
        REG_BOX_Y: box_q.y <= pwdata[30:0];
        REG_BOX_Z: box_q.z <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BOX_X: prdata = {1'b0, box_q.x};
      REG_BOX_Y: prdata = {1'b0, box_q.y};
      REG_BOX_Z: prdata = {1'b0, box_q.z};
      default:   prdata = 32'd0;
    endcase
  end

  // sphere memory: one write port for appends, one registered read port for the scan
  assign wr_en = accepted && (in_data_i.op == OP_APPEND) && !full;
  assign rd_en = (state_q == S_READ);
  assign wdata = '{center_x: in_data_i.coord_x, center_y: in_data_i.coord_y,
                   center_z: in_data_i.coord_z, diameter: in_data_i.diameter};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[fill_q[AddrW-1:0]] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[idx_q[AddrW-1:0]];
    end
  end

  // datapath control
  assign ctrl = '{load_mag: (state_q == S_MAG), mul_en: (state_q == S_MUL),
                  mul_sel: step_q, img_sel: step_q};

  psit_image_unit u_image (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .entry_i (rdata_q),
    .point_i (pt_q),
    .box_i   (box_q),
    .hit_o   (hit)
  );

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      idx_q       <= '0;
      fill_q      <= '0;
      inside_q    <= 1'b0;
      pt_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accepted) begin
            unique case (in_data_i.op)
              OP_CLEAR: begin
                fill_q <= '0;
                out_q  <= '{inside_res: 1'b0, entry_count: '0, status: 1'b0};
              end
              OP_APPEND: begin
                if (full) begin
                  out_q <= '{inside_res: 1'b0, entry_count: count_out(fill_q),
                             status: 1'b1};
                end else begin
                  fill_q <= fill_inc;
                  out_q  <= '{inside_res: 1'b0, entry_count: count_out(fill_inc),
                              status: 1'b0};
                end
              end
              OP_QUERY: begin
                pt_q <= '{x: in_data_i.coord_x, y: in_data_i.coord_y, z: in_data_i.coord_z};
                if (fill_q == '0) begin
                  out_q <= '{inside_res: 1'b0, entry_count: count_out(fill_q),
                             status: 1'b0};
                end else begin
                  idx_q    <= '0;
                  inside_q <= 1'b0;
                  state_q  <= S_READ;
                end
              end
              default: begin
                out_q <= '{inside_res: 1'b0, entry_count: count_out(fill_q),
                           status: 1'b0};
              end
            endcase
          end
        end
        S_READ: begin
          state_q <= S_MAG;
        end
        S_MAG: begin
          step_q  <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (step_q == STEP_W'(SQ_COUNT - 1)) begin
            step_q  <= '0;
            state_q <= S_CMP;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_CMP: begin
          if (hit) begin
            inside_q <= 1'b1;
            state_q  <= S_RESULT;
          end else if (step_q == STEP_W'(IMG_COUNT - 1)) begin
            step_q <= '0;
            if (last) begin
              state_q <= S_RESULT;
            end else begin
              idx_q   <= idx_inc;
              state_q <= S_READ;
            end
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_q   <= '{inside_res: inside_q, entry_count: count_out(fill_q),
                         status: 1'b0};
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
